// ===== hw/rtl/i2cm_pkg.sv =====
// Shared types, constants and helpers for the I2C register access master.
`default_nettype none

package i2cm_pkg;

   localparam int WAIT_WIDTH = 16;

   typedef logic [WAIT_WIDTH-1:0] wait_type;

   localparam logic [15:0] SETTLE_RESET = 16'd120;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_INIT      = 5'd1,
      PH_ST_REL    = 5'd2,
      PH_ST_SCLH   = 5'd3,
      PH_ST_SDALOW = 5'd4,
      PH_ST_SCLL   = 5'd5,
      PH_WB_DATA   = 5'd6,
      PH_WB_SCLH   = 5'd7,
      PH_WB_SCLL   = 5'd8,
      PH_ACK_REL   = 5'd9,
      PH_ACK_SCLH  = 5'd10,
      PH_ACK_SCLL  = 5'd11,
      PH_RB_REL    = 5'd12,
      PH_RB_SCLH   = 5'd13,
      PH_RB_SCLL   = 5'd14,
      PH_NK_REL    = 5'd15,
      PH_NK_SCLH   = 5'd16,
      PH_NK_SCLL   = 5'd17,
      PH_NK_REL2   = 5'd18,
      PH_SP_LOW    = 5'd19,
      PH_SP_SCLH   = 5'd20,
      PH_SP_REL    = 5'd21,
      PH_FINISH    = 5'd22
   } phase_type;

   // classified tick as it sits in the queue
   typedef struct packed {
      logic       is_cmd;
      logic       is_read;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       nack_seen;
      logic       command_rejected;
   } result_type;

   // byte sent in slot idx: address+W, register pointer, then data or address+R
   function automatic logic [7:0] byte_for(input logic [1:0] idx,
                                           input logic [6:0] dev,
                                           input logic [7:0] reg_addr,
                                           input logic [7:0] data,
                                           input logic       is_read);
      logic [7:0] b;
      if (idx == 2'd0) begin
         b = {dev, 1'b0};
      end else if (idx == 2'd1) begin
         b = reg_addr;
      end else if (is_read) begin
         b = {dev, 1'b1};
      end else begin
         b = data;
      end
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2cm_req_if.sv =====
// Request channel: one tick beat with optional command.
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [6:0] device_address;
   logic [7:0] register_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, output opcode, output device_address,
                   output register_address, output write_data, output sda_in,
                   input ready);
   modport sink (input valid, input opcode, input device_address,
                 input register_address, input write_data, input sda_in,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2cm_rsp_if.sv =====
// Response channel: pin drive and status beat for each tick.
`default_nettype none

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_pull_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       nack_seen;
   logic       command_rejected;

   modport source (output valid, output scl_level, output sda_pull_low,
                   output busy_res, output done_res, output read_data,
                   output nack_seen, output command_rejected, input ready);
   modport sink (input valid, input scl_level, input sda_pull_low,
                 input busy_res, input done_res, input read_data,
                 input nack_seen, input command_rejected, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2cm_front.sv =====
// Front end: accepts request beats, decodes the opcode, queues up to two items.
`default_nettype none

module i2cm_front (
   input  wire logic               clock,
   input  wire logic               reset,
   i2cm_req_if.sink                req,
   output i2cm_pkg::item_type      q_item,
   output logic                    q_valid,
   input  wire logic               q_pop
);

   i2cm_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   i2cm_pkg::item_type decoded;

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      decoded.is_cmd           = (req.opcode == i2cm_pkg::OP_WRITE) ||
                                 (req.opcode == i2cm_pkg::OP_READ);
      decoded.is_read          = (req.opcode == i2cm_pkg::OP_READ);
      decoded.device_address   = req.device_address;
      decoded.register_address = req.register_address;
      decoded.write_data       = req.write_data;
      decoded.sda_in           = req.sda_in;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cm_back.sv =====
// Back end: bus phase sequencer, settle timer and registered response beat.
`default_nettype none

module i2cm_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire i2cm_pkg::item_type q_item,
   input  wire logic               q_valid,
   output logic                    q_pop,
   input  wire logic               csr_write_enable,
   input  wire logic [15:0]        csr_write_data,
   i2cm_rsp_if.source              rsp
);

   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          bit_count_ff, bit_count_in;
   logic [1:0]          byte_index_ff, byte_index_in;
   logic [7:0]          shift_ff, shift_in;
   i2cm_pkg::wait_type  wait_ff, wait_in;
   logic                scl_ff, scl_in;
   logic                sda_low_ff, sda_low_in;
   logic [6:0]          dev_ff, dev_in;
   logic [7:0]          reg_addr_ff, reg_addr_in;
   logic [7:0]          data_ff, data_in;
   logic                is_read_ff, is_read_in;
   logic                nack_ff, nack_in;
   logic [7:0]          last_read_ff, last_read_in;
   logic [15:0]         settle_ff;
   logic                rsp_valid_ff;
   i2cm_pkg::result_type res_ff;

   logic                start;
   logic                rejected;
   logic                done;
   logic [1:0]          bi_next;
   logic [3:0]          bc_next;
   i2cm_pkg::wait_type  reload;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      start    = (phase_ff == i2cm_pkg::PH_IDLE) && q_item.is_cmd;
      rejected = (phase_ff != i2cm_pkg::PH_IDLE) && q_item.is_cmd;
      reload   = (settle_ff == 16'd0) ? '0 : i2cm_pkg::wait_type'(settle_ff - 16'd1);
      done     = 1'b0;
      bi_next  = 2'd0;
      bc_next  = 4'd0;

      phase_in      = start ? i2cm_pkg::PH_INIT : phase_ff;
      dev_in        = start ? q_item.device_address : dev_ff;
      reg_addr_in   = start ? q_item.register_address : reg_addr_ff;
      data_in       = start ? q_item.write_data : data_ff;
      is_read_in    = start ? q_item.is_read : is_read_ff;
      nack_in       = start ? 1'b0 : nack_ff;
      byte_index_in = start ? 2'd0 : byte_index_ff;
      bit_count_in  = start ? 4'd0 : bit_count_ff;
      shift_in      = start ? 8'd0 : shift_ff;
      wait_in       = start ? '0 : wait_ff;
      scl_in        = scl_ff;
      sda_low_in    = sda_low_ff;
      last_read_in  = last_read_ff;

      if (phase_in != i2cm_pkg::PH_IDLE) begin
         if (wait_in == '0) begin
            wait_in = reload;
            unique case (phase_in)
               i2cm_pkg::PH_INIT: begin
                  scl_in = 1'b1;
                  sda_low_in = 1'b0;
                  phase_in = i2cm_pkg::PH_ST_REL;
               end
               i2cm_pkg::PH_ST_REL: begin
                  sda_low_in = 1'b0;
                  phase_in = i2cm_pkg::PH_ST_SCLH;
               end
               i2cm_pkg::PH_ST_SCLH: begin
                  scl_in = 1'b1;
                  phase_in = i2cm_pkg::PH_ST_SDALOW;
               end
               i2cm_pkg::PH_ST_SDALOW: begin
                  sda_low_in = 1'b1;
                  phase_in = i2cm_pkg::PH_ST_SCLL;
               end
               i2cm_pkg::PH_ST_SCLL: begin
                  scl_in = 1'b0;
                  shift_in = i2cm_pkg::byte_for(byte_index_in, dev_in, reg_addr_in,
                                                data_in, is_read_in);
                  bit_count_in = 4'd0;
                  phase_in = i2cm_pkg::PH_WB_DATA;
               end
               i2cm_pkg::PH_WB_DATA: begin
                  sda_low_in = ~shift_in[7];
                  phase_in = i2cm_pkg::PH_WB_SCLH;
               end
               i2cm_pkg::PH_WB_SCLH: begin
                  scl_in = 1'b1;
                  phase_in = i2cm_pkg::PH_WB_SCLL;
               end
               i2cm_pkg::PH_WB_SCLL: begin
                  scl_in = 1'b0;
                  shift_in = {shift_in[6:0], 1'b0};
                  bc_next = bit_count_in + 4'd1;
                  bit_count_in = bc_next;
                  phase_in = (bc_next >= 4'd8) ? i2cm_pkg::PH_ACK_REL
                                               : i2cm_pkg::PH_WB_DATA;
               end
               i2cm_pkg::PH_ACK_REL: begin
                  sda_low_in = 1'b0;
                  phase_in = i2cm_pkg::PH_ACK_SCLH;
               end
               i2cm_pkg::PH_ACK_SCLH: begin
                  scl_in = 1'b1;
                  phase_in = i2cm_pkg::PH_ACK_SCLL;
               end
               i2cm_pkg::PH_ACK_SCLL: begin
                  if (q_item.sda_in) begin
                     nack_in = 1'b1;
                  end
                  scl_in = 1'b0;
                  bi_next = byte_index_in + 2'd1;
                  byte_index_in = bi_next;
                  bit_count_in = 4'd0;
                  if (!is_read_in) begin
                     if (bi_next != 2'd3) begin
                        shift_in = i2cm_pkg::byte_for(bi_next, dev_in, reg_addr_in,
                                                      data_in, is_read_in);
                        phase_in = i2cm_pkg::PH_WB_DATA;
                     end else begin
                        phase_in = i2cm_pkg::PH_SP_LOW;
                     end
                  end else if (bi_next == 2'd1) begin
                     shift_in = i2cm_pkg::byte_for(bi_next, dev_in, reg_addr_in,
                                                   data_in, is_read_in);
                     phase_in = i2cm_pkg::PH_WB_DATA;
                  end else if (bi_next == 2'd2) begin
                     phase_in = i2cm_pkg::PH_ST_REL;
                  end else begin
                     shift_in = 8'd0;
                     phase_in = i2cm_pkg::PH_RB_REL;
                  end
               end
               i2cm_pkg::PH_RB_REL: begin
                  sda_low_in = 1'b0;
                  shift_in = 8'd0;
                  bit_count_in = 4'd0;
                  phase_in = i2cm_pkg::PH_RB_SCLH;
               end
               i2cm_pkg::PH_RB_SCLH: begin
                  scl_in = 1'b1;
                  phase_in = i2cm_pkg::PH_RB_SCLL;
               end
               i2cm_pkg::PH_RB_SCLL: begin
                  shift_in = {shift_in[6:0], q_item.sda_in};
                  scl_in = 1'b0;
                  bc_next = bit_count_in + 4'd1;
                  bit_count_in = bc_next;
                  phase_in = (bc_next >= 4'd8) ? i2cm_pkg::PH_NK_REL
                                               : i2cm_pkg::PH_RB_SCLH;
               end
               i2cm_pkg::PH_NK_REL: begin
                  sda_low_in = 1'b0;
                  phase_in = i2cm_pkg::PH_NK_SCLH;
               end
               i2cm_pkg::PH_NK_SCLH: begin
                  scl_in = 1'b1;
                  phase_in = i2cm_pkg::PH_NK_SCLL;
               end
               i2cm_pkg::PH_NK_SCLL: begin
                  scl_in = 1'b0;
                  phase_in = i2cm_pkg::PH_NK_REL2;
               end
               i2cm_pkg::PH_NK_REL2: begin
                  sda_low_in = 1'b0;
                  last_read_in = shift_in;
                  phase_in = i2cm_pkg::PH_SP_LOW;
               end
               i2cm_pkg::PH_SP_LOW: begin
                  sda_low_in = 1'b1;
                  phase_in = i2cm_pkg::PH_SP_SCLH;
               end
               i2cm_pkg::PH_SP_SCLH: begin
                  scl_in = 1'b1;
                  phase_in = i2cm_pkg::PH_SP_REL;
               end
               i2cm_pkg::PH_SP_REL: begin
                  sda_low_in = 1'b0;
                  phase_in = i2cm_pkg::PH_FINISH;
               end
               default: begin
                  // ending tick: no line change
                  phase_in = i2cm_pkg::PH_IDLE;
                  wait_in = '0;
                  done = 1'b1;
               end
            endcase
         end else begin
            wait_in = wait_in - i2cm_pkg::wait_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cm_pkg::PH_IDLE;
      end else if (q_pop) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff  <= 4'd0;
         byte_index_ff <= 2'd0;
         shift_ff      <= 8'd0;
         wait_ff       <= '0;
         scl_ff        <= 1'b1;
         sda_low_ff    <= 1'b0;
         dev_ff        <= 7'd0;
         reg_addr_ff   <= 8'd0;
         data_ff       <= 8'd0;
         is_read_ff    <= 1'b0;
         nack_ff       <= 1'b0;
         last_read_ff  <= 8'd0;
      end else if (q_pop) begin
         bit_count_ff  <= bit_count_in;
         byte_index_ff <= byte_index_in;
         shift_ff      <= shift_in;
         wait_ff       <= wait_in;
         scl_ff        <= scl_in;
         sda_low_ff    <= sda_low_in;
         dev_ff        <= dev_in;
         reg_addr_ff   <= reg_addr_in;
         data_ff       <= data_in;
         is_read_ff    <= is_read_in;
         nack_ff       <= nack_in;
         last_read_ff  <= last_read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= i2cm_pkg::SETTLE_RESET;
      end else if (csr_write_enable) begin
         settle_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         res_ff.scl_level        <= scl_in;
         res_ff.sda_pull_low     <= sda_low_in;
         res_ff.busy_res         <= (phase_in != i2cm_pkg::PH_IDLE);
         res_ff.done_res         <= done;
         res_ff.read_data        <= last_read_in;
         res_ff.nack_seen        <= nack_in;
         res_ff.command_rejected <= rejected;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.scl_level        = res_ff.scl_level;
   assign rsp.sda_pull_low     = res_ff.sda_pull_low;
   assign rsp.busy_res         = res_ff.busy_res;
   assign rsp.done_res         = res_ff.done_res;
   assign rsp.read_data        = res_ff.read_data;
   assign rsp.nack_seen        = res_ff.nack_seen;
   assign rsp.command_rejected = res_ff.command_rejected;

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit counter past one byte");

   a_idle_no_wait: assert property (@(posedge clock) disable iff (reset)
      phase_ff == i2cm_pkg::PH_IDLE |-> wait_ff == '0)
      else $error("settle timer running while idle");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop && done |=> phase_ff == i2cm_pkg::PH_IDLE)
      else $error("sequencer not idle after ending tick");

   a_reject_keeps_held: assert property (@(posedge clock) disable iff (reset)
      q_pop && rejected |=> $stable(dev_ff) && $stable(reg_addr_ff) && $stable(data_ff))
      else $error("rejected command overwrote held transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_master_register_access.sv =====
// Top level of the I2C register access master: front queue and bus sequencer.
//
//   channel   dir  beat / write                         handshake
//   req_chan  in   opcode, addresses, data, sda_in      valid/ready
//   rsp_chan  out  pin drive, busy, done, data, flags   valid/ready
//   csr_*     in   settle_ticks (16 bits)               write enable
//
// One request beat is one bus tick; one response beat comes back per tick.
// Sustained rate is one beat per cycle while the response channel is ready; a beat
// passes through the two-entry front queue and then the sequencer's response register.
// Reset is synchronous: bus idle (SCL high, SDA released), settle 120 ticks.
// A stalled response holds the sequencer; the queue keeps taking beats until full.
`default_nettype none

module i2c_master_register_access (
   input  wire logic        clock,
   input  wire logic        reset,
   i2cm_req_if.sink         req_chan,
   i2cm_rsp_if.source       rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   i2cm_pkg::item_type q_item;
   logic               q_valid;
   logic               q_pop;

   i2cm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   i2cm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_item           (q_item),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp              (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the I2C register access master: scoreboard against a tick predictor.
`default_nettype none

module tb;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int SDA_LOW = 0;
   localparam int SDA_HIGH = 1;
   localparam int SDA_RANDOM = 2;
   localparam int LONG_HOLD = 80;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } tick_beat_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   i2cm_req_if req_chan();
   i2cm_rsp_if rsp_chan();

   i2c_master_register_access dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predicted bus sequencer state
   logic [15:0]         bus_settle;
   i2cm_pkg::phase_type bus_phase;
   logic [3:0]          bus_bits;
   logic [1:0]          bus_slot;
   logic [7:0]          bus_shift;
   logic [15:0]         bus_wait;
   logic                bus_scl;
   logic                bus_sda_low;
   logic [6:0]          bus_device;
   logic [7:0]          bus_register;
   logic [7:0]          bus_data;
   logic                bus_is_read;
   logic                bus_nack;
   logic [7:0]          bus_last_read;

   i2cm_pkg::result_type pin_beats_due[$];
   i2cm_pkg::result_type due_beat;
   int          mismatches;
   bit          steady;
   bit          hold_request;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic logic [7:0] slot_byte(input logic [1:0] slot);
      if (slot == 2'd0) return {bus_device, 1'b0};
      if (slot == 2'd1) return bus_register;
      return bus_is_read ? {bus_device, 1'b1} : bus_data;
   endfunction

   // one bus step; returns 1 when the transaction ends
   function automatic logic bus_step(input logic sda);
      i2cm_pkg::phase_type nxt;
      nxt = i2cm_pkg::PH_IDLE;
      case (bus_phase)
         i2cm_pkg::PH_INIT: begin
            bus_scl = 1'b1;
            bus_sda_low = 1'b0;
            nxt = i2cm_pkg::PH_ST_REL;
         end
         i2cm_pkg::PH_ST_REL: begin
            bus_sda_low = 1'b0;
            nxt = i2cm_pkg::PH_ST_SCLH;
         end
         i2cm_pkg::PH_ST_SCLH: begin
            bus_scl = 1'b1;
            nxt = i2cm_pkg::PH_ST_SDALOW;
         end
         i2cm_pkg::PH_ST_SDALOW: begin
            bus_sda_low = 1'b1;
            nxt = i2cm_pkg::PH_ST_SCLL;
         end
         i2cm_pkg::PH_ST_SCLL: begin
            bus_scl = 1'b0;
            bus_shift = slot_byte(bus_slot);
            bus_bits = 4'd0;
            nxt = i2cm_pkg::PH_WB_DATA;
         end
         i2cm_pkg::PH_WB_DATA: begin
            bus_sda_low = ~bus_shift[7];
            nxt = i2cm_pkg::PH_WB_SCLH;
         end
         i2cm_pkg::PH_WB_SCLH: begin
            bus_scl = 1'b1;
            nxt = i2cm_pkg::PH_WB_SCLL;
         end
         i2cm_pkg::PH_WB_SCLL: begin
            bus_scl = 1'b0;
            bus_shift = {bus_shift[6:0], 1'b0};
            bus_bits = bus_bits + 4'd1;
            nxt = (bus_bits >= 4'd8) ? i2cm_pkg::PH_ACK_REL : i2cm_pkg::PH_WB_DATA;
         end
         i2cm_pkg::PH_ACK_REL: begin
            bus_sda_low = 1'b0;
            nxt = i2cm_pkg::PH_ACK_SCLH;
         end
         i2cm_pkg::PH_ACK_SCLH: begin
            bus_scl = 1'b1;
            nxt = i2cm_pkg::PH_ACK_SCLL;
         end
         i2cm_pkg::PH_ACK_SCLL: begin
            if (sda) bus_nack = 1'b1;
            bus_scl = 1'b0;
            bus_slot = bus_slot + 2'd1;
            bus_bits = 4'd0;
            if (!bus_is_read) begin
               if (bus_slot < 2'd3) begin
                  bus_shift = slot_byte(bus_slot);
                  nxt = i2cm_pkg::PH_WB_DATA;
               end else begin
                  nxt = i2cm_pkg::PH_SP_LOW;
               end
            end else if (bus_slot == 2'd1) begin
               bus_shift = slot_byte(2'd1);
               nxt = i2cm_pkg::PH_WB_DATA;
            end else if (bus_slot == 2'd2) begin
               nxt = i2cm_pkg::PH_ST_REL;
            end else begin
               bus_shift = 8'd0;
               nxt = i2cm_pkg::PH_RB_REL;
            end
         end
         i2cm_pkg::PH_RB_REL: begin
            bus_sda_low = 1'b0;
            bus_shift = 8'd0;
            bus_bits = 4'd0;
            nxt = i2cm_pkg::PH_RB_SCLH;
         end
         i2cm_pkg::PH_RB_SCLH: begin
            bus_scl = 1'b1;
            nxt = i2cm_pkg::PH_RB_SCLL;
         end
         i2cm_pkg::PH_RB_SCLL: begin
            bus_shift = {bus_shift[6:0], sda};
            bus_scl = 1'b0;
            bus_bits = bus_bits + 4'd1;
            nxt = (bus_bits >= 4'd8) ? i2cm_pkg::PH_NK_REL : i2cm_pkg::PH_RB_SCLH;
         end
         i2cm_pkg::PH_NK_REL: begin
            bus_sda_low = 1'b0;
            nxt = i2cm_pkg::PH_NK_SCLH;
         end
         i2cm_pkg::PH_NK_SCLH: begin
            bus_scl = 1'b1;
            nxt = i2cm_pkg::PH_NK_SCLL;
         end
         i2cm_pkg::PH_NK_SCLL: begin
            bus_scl = 1'b0;
            nxt = i2cm_pkg::PH_NK_REL2;
         end
         i2cm_pkg::PH_NK_REL2: begin
            bus_sda_low = 1'b0;
            bus_last_read = bus_shift;
            nxt = i2cm_pkg::PH_SP_LOW;
         end
         i2cm_pkg::PH_SP_LOW: begin
            bus_sda_low = 1'b1;
            nxt = i2cm_pkg::PH_SP_SCLH;
         end
         i2cm_pkg::PH_SP_SCLH: begin
            bus_scl = 1'b1;
            nxt = i2cm_pkg::PH_SP_REL;
         end
         i2cm_pkg::PH_SP_REL: begin
            bus_sda_low = 1'b0;
            nxt = i2cm_pkg::PH_FINISH;
         end
         default: begin
            bus_phase = i2cm_pkg::PH_IDLE;
            bus_wait = 16'd0;
            return 1'b1;
         end
      endcase
      bus_phase = nxt;
      // a settle of zero behaves as one
      bus_wait = (bus_settle == 16'd0) ? 16'd0 : bus_settle - 16'd1;
      return 1'b0;
   endfunction

   function automatic void predict_tick(input tick_beat_type b);
      logic       is_cmd;
      logic       rejected;
      logic       done;
      i2cm_pkg::result_type r;
      is_cmd = (b.opcode == i2cm_pkg::OP_WRITE) || (b.opcode == i2cm_pkg::OP_READ);
      rejected = 1'b0;
      done = 1'b0;
      if (bus_phase == i2cm_pkg::PH_IDLE) begin
         if (is_cmd) begin
            bus_device = b.device_address;
            bus_register = b.register_address;
            bus_data = b.write_data;
            bus_is_read = (b.opcode == i2cm_pkg::OP_READ);
            bus_nack = 1'b0;
            bus_slot = 2'd0;
            bus_bits = 4'd0;
            bus_shift = 8'd0;
            bus_wait = 16'd0;
            bus_phase = i2cm_pkg::PH_INIT;
         end
      end else if (is_cmd) begin
         rejected = 1'b1;
      end
      if (bus_phase != i2cm_pkg::PH_IDLE) begin
         if (bus_wait == 16'd0) done = bus_step(b.sda_in);
         else bus_wait = bus_wait - 16'd1;
      end
      r.scl_level = bus_scl;
      r.sda_pull_low = bus_sda_low;
      r.busy_res = (bus_phase != i2cm_pkg::PH_IDLE);
      r.done_res = done;
      r.read_data = bus_last_read;
      r.nack_seen = bus_nack;
      r.command_rejected = rejected;
      pin_beats_due.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pin_beats_due.size() == 0) begin
            $error("response beat with nothing outstanding");
            mismatches++;
         end else begin
            due_beat = pin_beats_due.pop_front();
            check_field("scl_level", 8'(due_beat.scl_level), 8'(rsp_chan.scl_level));
            check_field("sda_pull_low", 8'(due_beat.sda_pull_low),
                        8'(rsp_chan.sda_pull_low));
            check_field("busy_res", 8'(due_beat.busy_res), 8'(rsp_chan.busy_res));
            check_field("done_res", 8'(due_beat.done_res), 8'(rsp_chan.done_res));
            check_field("read_data", due_beat.read_data, rsp_chan.read_data);
            check_field("nack_seen", 8'(due_beat.nack_seen), 8'(rsp_chan.nack_seen));
            check_field("command_rejected", 8'(due_beat.command_rejected),
                        8'(rsp_chan.command_rejected));
         end
      end
   end

   // response sink: random stalls, plus the long hold-off on request
   initial begin
      int n;
      int r;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (hold_request) begin
            hold_request = 1'b0;
            n = LONG_HOLD;
         end else if (steady || r < 75) begin
            n = 0;
         end else if (r < 95) begin
            n = $urandom_range(1, 4);
         end else begin
            n = $urandom_range(8, 20);
         end
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   task automatic send_beat(input tick_beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= b.opcode;
      req_chan.device_address <= b.device_address;
      req_chan.register_address <= b.register_address;
      req_chan.write_data <= b.write_data;
      req_chan.sda_in <= b.sda_in;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_tick(b);
   endtask

   function automatic tick_beat_type filler(input int sda_mode);
      tick_beat_type b;
      b.opcode = ($urandom_range(0, 9) == 0) ? OP_SPARE : i2cm_pkg::OP_TICK;
      b.device_address = 7'($urandom);
      b.register_address = 8'($urandom);
      b.write_data = 8'($urandom);
      case (sda_mode)
         SDA_LOW: b.sda_in = 1'b0;
         SDA_HIGH: b.sda_in = 1'b1;
         default: b.sda_in = 1'($urandom_range(0, 1));
      endcase
      return b;
   endfunction

   function automatic tick_beat_type random_beat();
      tick_beat_type b;
      int r;
      b = filler(SDA_RANDOM);
      r = $urandom_range(0, 99);
      if (bus_phase == i2cm_pkg::PH_IDLE) begin
         if (r < 85) b.opcode = $urandom_range(0, 1) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ;
      end else if (bus_phase == i2cm_pkg::PH_FINISH && bus_wait == 16'd0) begin
         if (r < 50) b.opcode = $urandom_range(0, 1) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ;
      end else if (r < 3) begin
         b.opcode = $urandom_range(0, 1) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ;
      end
      // mostly acknowledged, with some missing acks
      if (bus_phase == i2cm_pkg::PH_ACK_SCLL && bus_wait == 16'd0 &&
          $urandom_range(0, 99) < 80)
         b.sda_in = 1'b0;
      return b;
   endfunction

   task automatic finish_transaction(input int sda_mode);
      while (bus_phase != i2cm_pkg::PH_IDLE) send_beat(filler(sda_mode));
   endtask

   task automatic run_command(input logic [1:0] op, input logic [6:0] dev,
                              input logic [7:0] reg_addr, input logic [7:0] data,
                              input int sda_mode);
      tick_beat_type b;
      b = filler(sda_mode);
      b.opcode = op;
      b.device_address = dev;
      b.register_address = reg_addr;
      b.write_data = data;
      send_beat(b);
      finish_transaction(sda_mode);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pin_beats_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settle(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bus_settle = value;
      @(posedge clock);
   endtask

   task automatic test_idle_ticks();
      repeat (6) send_beat(filler(SDA_RANDOM));
      wait_drained();
   endtask

   task automatic test_longest_settle();
      write_settle(16'hFFFF);
      repeat (5) send_beat(filler(SDA_RANDOM));
      wait_drained();
   endtask

   task automatic test_write_extremes();
      write_settle(16'd1);
      run_command(i2cm_pkg::OP_WRITE, 7'h7F, 8'hFF, 8'hFF, SDA_LOW);
      wait_drained();
   endtask

   task automatic test_read_extremes();
      run_command(i2cm_pkg::OP_READ, 7'h7F, 8'hFF, 8'h00, SDA_HIGH);
      wait_drained();
   endtask

   task automatic test_rejects();
      tick_beat_type b;
      int count;
      b = filler(SDA_LOW);
      b.opcode = i2cm_pkg::OP_WRITE;
      send_beat(b);
      count = 0;
      while (bus_phase != i2cm_pkg::PH_IDLE) begin
         b = filler(SDA_RANDOM);
         if (bus_phase == i2cm_pkg::PH_FINISH && bus_wait == 16'd0)
            b.opcode = i2cm_pkg::OP_READ;
         else if (count % 17 == 5) b.opcode = i2cm_pkg::OP_WRITE;
         else if (count % 17 == 11) b.opcode = i2cm_pkg::OP_READ;
         send_beat(b);
         count++;
      end
      // first tick after done takes a command at once
      run_command(i2cm_pkg::OP_READ, 7'h3C, 8'hC3, 8'h00, SDA_RANDOM);
      wait_drained();
   endtask

   task automatic test_zero_settle();
      write_settle(16'd0);
      // read data must survive a following write
      run_command(i2cm_pkg::OP_WRITE, 7'h00, 8'h00, 8'h00, SDA_HIGH);
      wait_drained();
   endtask

   task automatic test_slow_settle();
      write_settle(16'd2);
      run_command(i2cm_pkg::OP_WRITE, 7'h55, 8'hA5, 8'h3C, SDA_RANDOM);
      wait_drained();
   endtask

   task automatic test_backpressure();
      write_settle(16'd1);
      steady = 1'b1;
      hold_request = 1'b1;
      repeat (40) send_beat(random_beat());
      steady = 1'b0;
      finish_transaction(SDA_RANDOM);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < 2; p++) begin
         steady = (p == 1);
         repeat (50) send_beat(random_beat());
         finish_transaction(SDA_RANDOM);
         steady = 1'b0;
         wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 16'd0;
      req_chan.valid = 1'b0;
      req_chan.opcode = i2cm_pkg::OP_TICK;
      req_chan.device_address = 7'd0;
      req_chan.register_address = 8'd0;
      req_chan.write_data = 8'd0;
      req_chan.sda_in = 1'b0;
      mismatches = 0;
      steady = 1'b0;
      hold_request = 1'b0;
      bus_settle = i2cm_pkg::SETTLE_RESET;
      bus_phase = i2cm_pkg::PH_IDLE;
      bus_bits = 4'd0;
      bus_slot = 2'd0;
      bus_shift = 8'd0;
      bus_wait = 16'd0;
      bus_scl = 1'b1;
      bus_sda_low = 1'b0;
      bus_device = 7'd0;
      bus_register = 8'd0;
      bus_data = 8'd0;
      bus_is_read = 1'b0;
      bus_nack = 1'b0;
      bus_last_read = 8'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_ticks();
      test_longest_settle();
      test_write_extremes();
      test_read_extremes();
      test_rejects();
      test_zero_settle();
      test_slow_settle();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_req_if.sv
hw/rtl/i2cm_rsp_if.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_back.sv
hw/rtl/i2c_master_register_access.sv
bench/tb.sv
